// ----- rtl/eor_pkg.sv -----
// shared constants and types for the ellipse outline rasterizer
`default_nettype none

package eor_pkg;

  localparam int unsigned CENTER_W   = 12;
  localparam int unsigned TARGET_W   = 12;
  localparam int unsigned STEP_W     = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEMI_A        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEMI_B        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd5;

  localparam logic [TARGET_W-1:0] TARGET_WIDTH_RST  = 12'd640;
  localparam logic [TARGET_W-1:0] TARGET_HEIGHT_RST = 12'd480;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  typedef struct packed {
    logic [TARGET_W-1:0] width;
    logic [TARGET_W-1:0] height;
  } clip_t;

endpackage

`default_nettype wire

// ----- rtl/ellipse_outline_rasterizer_top.sv -----
// midpoint ellipse outline generator with a shared adder and multiplier
//
// config: write a register index and data on the cfg channel while idle;
//   cfg_ready_o is always high.
// input: one beat carries restart_i. a restart beat loads the first pass from
//   the semi-axis registers; any other beat advances the generator by one
//   loop iteration. every input beat yields exactly one output beat.
// output: four points, their inside mask, points_valid and finished.
// steps: a restart beat runs three products on the shared multiplier and
//   two adds on the shared adder, and a beat that changes pass runs the
//   same after its test; an iteration tests and updates on one shared
//   error-width adder, with two more adds when the row steps; a beat that
//   ends the last pass only tests, and one that arrives when finished emits.
// flow: one beat in flight at a time; in_ready_o is high only while the
//   sequencer is idle, which it enters after each result write.
// the output register holds a result until taken; the next input beat is
//   accepted meanwhile and its work stalls only at the final write.
// reset: the generator is finished, centre and axes are zero and the target
//   is 640 by 480.
`default_nettype none

module ellipse_outline_rasterizer_top #(
  parameter int unsigned COORD_BITS = 13,
  parameter int unsigned AXIS_BITS  = 10,
  parameter int unsigned ERROR_BITS = 40
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [eor_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [eor_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                restart_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [COORD_BITS-1:0]             pt0_x_o,
  output logic signed [COORD_BITS-1:0]             pt0_y_o,
  output logic signed [COORD_BITS-1:0]             pt1_x_o,
  output logic signed [COORD_BITS-1:0]             pt1_y_o,
  output logic signed [COORD_BITS-1:0]             pt2_x_o,
  output logic signed [COORD_BITS-1:0]             pt2_y_o,
  output logic signed [COORD_BITS-1:0]             pt3_x_o,
  output logic signed [COORD_BITS-1:0]             pt3_y_o,
  output logic        [3:0]                        inside_mask_o,
  output logic                                     points_valid_o,
  output logic                                     finished_o
);

  localparam int unsigned E      = ERROR_BITS;
  localparam int unsigned SQ_W   = 2 * AXIS_BITS;
  localparam int unsigned PROD_W = 3 * AXIS_BITS;
  localparam int unsigned ROW_W  = AXIS_BITS + 1;
  localparam int unsigned WIDE_W = (E > PROD_W + 3) ? E : PROD_W + 3;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_TEST     = 4'd1;
  localparam logic [3:0] ST_ERR_DS   = 4'd2;
  localparam logic [3:0] ST_ERR_SQ   = 4'd3;
  localparam logic [3:0] ST_ERR_DR   = 4'd4;
  localparam logic [3:0] ST_DROW     = 4'd5;
  localparam logic [3:0] ST_DSTEP    = 4'd6;
  localparam logic [3:0] ST_MUL_MIN  = 4'd7;
  localparam logic [3:0] ST_MUL_MAJ  = 4'd8;
  localparam logic [3:0] ST_MUL_DR   = 4'd9;
  localparam logic [3:0] ST_INIT_ERR = 4'd10;
  localparam logic [3:0] ST_SUB_ERR  = 4'd11;
  localparam logic [3:0] ST_EMIT     = 4'd12;

  // config registers
  logic signed [eor_pkg::CENTER_W-1:0] center_x_q, center_y_q;
  logic        [AXIS_BITS-1:0]         semi_a_q, semi_b_q;
  logic        [eor_pkg::TARGET_W-1:0] target_width_q, target_height_q;
  eor_pkg::clip_t                      clip;

  // sequencer and generator state
  logic [3:0]                  state_q, state_d;
  logic [1:0]                  phase_q, phase_d;
  logic                        swap_q, swap_d;
  logic                        pv_q, pv_d;
  logic                        err_le_q, err_le_d;
  logic [eor_pkg::STEP_W-1:0]  step_q, step_d;
  logic signed [ROW_W-1:0]     row_q, row_d;
  logic [E-1:0]                err_q, err_d;
  logic [E-1:0]                dstep_q, dstep_d;
  logic [E-1:0]                drow_q, drow_d;
  logic [SQ_W-1:0]             sq_minor_q, sq_minor_d;
  logic [SQ_W-1:0]             sq_major_q, sq_major_d;
  logic [PROD_W-1:0]           prod_q, prod_d;

  // shared units
  logic [E-1:0]      add_a, add_b;
  logic              add_sub;
  logic [E:0]        add_a_x, add_b_x, add_sum;
  logic [SQ_W-1:0]   mul_x;
  logic [AXIS_BITS-1:0] mul_y;
  logic [PROD_W-1:0] mul_p;

  logic [AXIS_BITS-1:0] step_src, row_src;
  logic [WIDE_W-1:0]    w_min4, w_min8, w_maj, w_maj8, w_prod4, w_prod8;
  logic                 out_load;
  logic                 out_valid_q;

  logic signed [COORD_BITS-1:0] pt_x [4];
  logic signed [COORD_BITS-1:0] pt_y [4];
  logic        [3:0]            pt_mask;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign clip.width  = target_width_q;
  assign clip.height = target_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q      <= '0;
      center_y_q      <= '0;
      semi_a_q        <= '0;
      semi_b_q        <= '0;
      target_width_q  <= eor_pkg::TARGET_WIDTH_RST;
      target_height_q <= eor_pkg::TARGET_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        eor_pkg::CFG_CENTER_X:      center_x_q      <= cfg_data_i[eor_pkg::CENTER_W-1:0];
        eor_pkg::CFG_CENTER_Y:      center_y_q      <= cfg_data_i[eor_pkg::CENTER_W-1:0];
        eor_pkg::CFG_SEMI_A:        semi_a_q        <= cfg_data_i[AXIS_BITS-1:0];
        eor_pkg::CFG_SEMI_B:        semi_b_q        <= cfg_data_i[AXIS_BITS-1:0];
        eor_pkg::CFG_TARGET_WIDTH:  target_width_q  <= cfg_data_i[eor_pkg::TARGET_W-1:0];
        eor_pkg::CFG_TARGET_HEIGHT: target_height_q <= cfg_data_i[eor_pkg::TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  // shared adder, one extra bit gives the signed compare
  assign add_a_x = {add_a[E-1], add_a};
  assign add_b_x = {add_b[E-1], add_b};
  assign add_sum = add_a_x + (add_sub ? ~add_b_x : add_b_x) + (E+1)'(add_sub);

  // shared multiplier
  assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

  assign step_src = swap_q ? semi_a_q : semi_b_q;
  assign row_src  = swap_q ? semi_b_q : semi_a_q;

  assign w_min4  = WIDE_W'(sq_minor_q) << 2;
  assign w_min8  = WIDE_W'(sq_minor_q) << 3;
  assign w_maj   = WIDE_W'(sq_major_q);
  assign w_maj8  = WIDE_W'(sq_major_q) << 3;
  assign w_prod4 = WIDE_W'(prod_q) << 2;
  assign w_prod8 = WIDE_W'(prod_q) << 3;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    swap_d     = swap_q;
    pv_d       = pv_q;
    err_le_d   = err_le_q;
    step_d     = step_q;
    row_d      = row_q;
    err_d      = err_q;
    dstep_d    = dstep_q;
    drow_d     = drow_q;
    sq_minor_d = sq_minor_q;
    sq_major_d = sq_major_q;
    prod_d     = prod_q;
    add_a      = err_q;
    add_b      = drow_q;
    add_sub    = 1'b0;
    mul_x      = SQ_W'(step_src);
    mul_y      = step_src;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (restart_i) begin
            swap_d  = 1'b0;
            state_d = ST_MUL_MIN;
          end else if (phase_q[1]) begin
            pv_d    = 1'b0;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_TEST;
          end
        end
      end
      ST_TEST: begin
        add_a   = dstep_q;
        add_b   = drow_q;
        add_sub = 1'b1;
        if (add_sum[E] && (step_q < target_width_q) && !row_q[ROW_W-1]) begin
          err_le_d = err_q[E-1] | (err_q == '0);
          state_d  = ST_ERR_DS;
        end else if (phase_q == eor_pkg::PH_FIRST) begin
          swap_d  = 1'b1;
          state_d = ST_MUL_MIN;
        end else begin
          phase_d = eor_pkg::PH_DONE;
          pv_d    = 1'b0;
          state_d = ST_EMIT;
        end
      end
      ST_ERR_DS: begin
        add_b   = dstep_q;
        err_d   = add_sum[E-1:0];
        state_d = ST_ERR_SQ;
      end
      ST_ERR_SQ: begin
        add_b   = w_min4[E-1:0];
        err_d   = add_sum[E-1:0];
        state_d = err_le_q ? ST_DSTEP : ST_ERR_DR;
      end
      ST_ERR_DR: begin
        add_b   = drow_q;
        add_sub = 1'b1;
        err_d   = add_sum[E-1:0];
        state_d = ST_DROW;
      end
      ST_DROW: begin
        add_a   = drow_q;
        add_b   = w_maj8[E-1:0];
        add_sub = 1'b1;
        drow_d  = add_sum[E-1:0];
        row_d   = row_q - ROW_W'(1);
        state_d = ST_DSTEP;
      end
      ST_DSTEP: begin
        add_a   = dstep_q;
        add_b   = w_min8[E-1:0];
        dstep_d = add_sum[E-1:0];
        pv_d    = 1'b1;
        state_d = ST_EMIT;
      end
      ST_MUL_MIN: begin
        sq_minor_d = mul_p[SQ_W-1:0];
        phase_d    = swap_q ? eor_pkg::PH_SECOND : eor_pkg::PH_FIRST;
        step_d     = '0;
        row_d      = {1'b0, step_src};
        dstep_d    = '0;
        state_d    = ST_MUL_MAJ;
      end
      ST_MUL_MAJ: begin
        mul_x      = SQ_W'(row_src);
        mul_y      = row_src;
        sq_major_d = mul_p[SQ_W-1:0];
        state_d    = ST_MUL_DR;
      end
      ST_MUL_DR: begin
        mul_x   = sq_major_q;
        prod_d  = mul_p;
        state_d = ST_INIT_ERR;
      end
      ST_INIT_ERR: begin
        add_a   = w_min4[E-1:0];
        add_b   = w_maj[E-1:0];
        err_d   = add_sum[E-1:0];
        drow_d  = w_prod8[E-1:0];
        state_d = ST_SUB_ERR;
      end
      ST_SUB_ERR: begin
        add_b   = w_prod4[E-1:0];
        add_sub = 1'b1;
        err_d   = add_sum[E-1:0];
        pv_d    = 1'b0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (pv_q) begin
            step_d = step_q + eor_pkg::STEP_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= eor_pkg::PH_DONE;
      swap_q     <= 1'b0;
      pv_q       <= 1'b0;
      err_le_q   <= 1'b0;
      step_q     <= '0;
      row_q      <= '0;
      err_q      <= '0;
      dstep_q    <= '0;
      drow_q     <= '0;
      sq_minor_q <= '0;
      sq_major_q <= '0;
      prod_q     <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      swap_q     <= swap_d;
      pv_q       <= pv_d;
      err_le_q   <= err_le_d;
      step_q     <= step_d;
      row_q      <= row_d;
      err_q      <= err_d;
      dstep_q    <= dstep_d;
      drow_q     <= drow_d;
      sq_minor_q <= sq_minor_d;
      sq_major_q <= sq_major_d;
      prod_q     <= prod_d;
    end
  end

  eor_points #(
    .COORD_BITS (COORD_BITS),
    .AXIS_BITS  (AXIS_BITS)
  ) u_points (
    .center_x_i    (center_x_q),
    .center_y_i    (center_y_q),
    .step_i        (step_q),
    .row_i         (row_q),
    .second_pass_i (phase_q[0]),
    .clip_i        (clip),
    .pt_x_o        (pt_x),
    .pt_y_o        (pt_y),
    .mask_o        (pt_mask)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      pt0_x_o        <= '0;
      pt0_y_o        <= '0;
      pt1_x_o        <= '0;
      pt1_y_o        <= '0;
      pt2_x_o        <= '0;
      pt2_y_o        <= '0;
      pt3_x_o        <= '0;
      pt3_y_o        <= '0;
      inside_mask_o  <= '0;
      points_valid_o <= 1'b0;
      finished_o     <= 1'b0;
    end else if (out_load) begin
      out_valid_q    <= 1'b1;
      pt0_x_o        <= pv_q ? pt_x[0] : '0;
      pt0_y_o        <= pv_q ? pt_y[0] : '0;
      pt1_x_o        <= pv_q ? pt_x[1] : '0;
      pt1_y_o        <= pv_q ? pt_y[1] : '0;
      pt2_x_o        <= pv_q ? pt_x[2] : '0;
      pt2_y_o        <= pv_q ? pt_y[2] : '0;
      pt3_x_o        <= pv_q ? pt_x[3] : '0;
      pt3_y_o        <= pv_q ? pt_y[3] : '0;
      inside_mask_o  <= pv_q ? pt_mask : '0;
      points_valid_o <= pv_q;
      finished_o     <= phase_q[1];
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/eor_points.sv -----
// four mirrored outline points and their inside mask
`default_nettype none

module eor_points #(
  parameter int unsigned COORD_BITS = 13,
  parameter int unsigned AXIS_BITS  = 10
) (
  input  wire logic signed [eor_pkg::CENTER_W-1:0] center_x_i,
  input  wire logic signed [eor_pkg::CENTER_W-1:0] center_y_i,
  input  wire logic        [eor_pkg::STEP_W-1:0]   step_i,
  input  wire logic signed [AXIS_BITS:0]           row_i,
  input  wire logic                                second_pass_i,
  input  wire eor_pkg::clip_t                      clip_i,
  output logic signed      [COORD_BITS-1:0]        pt_x_o [4],
  output logic signed      [COORD_BITS-1:0]        pt_y_o [4],
  output logic             [3:0]                   mask_o
);

  localparam int unsigned FW = (AXIS_BITS + 2 > 14) ? AXIS_BITS + 2 : 14;
  localparam int unsigned WW = (FW > COORD_BITS) ? FW : COORD_BITS;

  logic signed [FW-1:0] cx, cy, s_ext, r_ext, x_off, y_off;
  logic signed [FW-1:0] px [4];
  logic signed [FW-1:0] py [4];
  logic signed [WW-1:0] px_w [4];
  logic signed [WW-1:0] py_w [4];
  logic        [FW-1:0] tw_ext, th_ext;

  always_comb begin
    cx     = FW'(center_x_i);
    cy     = FW'(center_y_i);
    s_ext  = $signed({{(FW-eor_pkg::STEP_W){1'b0}}, step_i});
    r_ext  = FW'(row_i);
    x_off  = second_pass_i ? r_ext : s_ext;
    y_off  = second_pass_i ? s_ext : r_ext;
    tw_ext = FW'(clip_i.width);
    th_ext = FW'(clip_i.height);
    for (int i = 0; i < 4; i++) begin
      // mirror pattern differs between the two passes
      if (second_pass_i ? i[0] : i[1]) begin
        px[i] = cx - x_off;
      end else begin
        px[i] = cx + x_off;
      end
      if (second_pass_i ? i[1] : i[0]) begin
        py[i] = cy - y_off;
      end else begin
        py[i] = cy + y_off;
      end
      px_w[i]   = WW'(px[i]);
      py_w[i]   = WW'(py[i]);
      pt_x_o[i] = px_w[i][COORD_BITS-1:0];
      pt_y_o[i] = py_w[i][COORD_BITS-1:0];
      mask_o[i] = !px[i][FW-1] && (px[i] < tw_ext) && !py[i][FW-1] && (py[i] < th_ext);
    end
  end

endmodule

`default_nettype wire

// ----- bench/ellipse_outline_rasterizer_checker.sv -----
// outline predictor and result checker for the ellipse outline rasterizer
`timescale 1ns / 100ps

module ellipse_outline_rasterizer_checker #(
  parameter int unsigned COORD_W = 13,
  parameter int unsigned AXIS_W  = 10,
  parameter int unsigned ERR_W   = 40
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  input  wire logic                                cfg_ready_i,
  input  wire logic [eor_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [eor_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_ready_i,
  input  wire logic                                restart_i,
  input  wire logic                                out_valid_i,
  input  wire logic                                out_ready_i,
  input  wire logic [COORD_W-1:0]                  pt0_x_i,
  input  wire logic [COORD_W-1:0]                  pt0_y_i,
  input  wire logic [COORD_W-1:0]                  pt1_x_i,
  input  wire logic [COORD_W-1:0]                  pt1_y_i,
  input  wire logic [COORD_W-1:0]                  pt2_x_i,
  input  wire logic [COORD_W-1:0]                  pt2_y_i,
  input  wire logic [COORD_W-1:0]                  pt3_x_i,
  input  wire logic [COORD_W-1:0]                  pt3_y_i,
  input  wire logic [3:0]                          inside_mask_i,
  input  wire logic                                points_valid_i,
  input  wire logic                                finished_i,
  output int                                       mismatch_count_o,
  output int                                       pending_o
);

  typedef struct packed {
    logic [3:0][COORD_W-1:0] px;
    logic [3:0][COORD_W-1:0] py;
    logic [3:0]              mask;
    logic                    pv;
    logic                    fin;
  } outline_t;

  logic [eor_pkg::CENTER_W-1:0]   center_x, center_y;
  logic [AXIS_W-1:0]              semi_a, semi_b;
  logic [eor_pkg::TARGET_W-1:0]   target_w, target_h;

  logic [1:0]            phase;
  int                    step_pos, row_pos;
  logic [ERR_W-1:0]      err_acc, d_step, d_row;
  logic [2*AXIS_W-1:0]   sq_step, sq_row;

  outline_t              pending_outlines[$];

  function automatic void load_arc(input logic [1:0] ph, input logic [2*AXIS_W-1:0] step_sq,
                                   input logic [2*AXIS_W-1:0] row_sq,
                                   input logic [AXIS_W-1:0] start_row);
    longint unsigned ss, rs, rr;
    logic [63:0] acc;
    ss = step_sq;
    rs = row_sq;
    rr = start_row;
    phase = ph;
    sq_step = step_sq;
    sq_row = row_sq;
    step_pos = 0;
    row_pos = start_row;
    d_step = '0;
    acc = 8 * rs * rr;
    d_row = acc[ERR_W-1:0];
    acc = 4 * ss - 4 * rs * rr + rs;
    err_acc = acc[ERR_W-1:0];
  endfunction

  function automatic outline_t trace_outline_tick(input logic restart);
    outline_t r;
    logic [2*AXIS_W-1:0] sqa, sqb;
    int cx, cy, tw, th, t;
    int px[4], py[4];
    r = '0;
    sqa = semi_a * semi_a;
    sqb = semi_b * semi_b;
    tw = target_w;
    th = target_h;
    if (restart) begin
      load_arc(eor_pkg::PH_FIRST, sqb, sqa, semi_b);
      return r;
    end
    if (phase != eor_pkg::PH_FIRST && phase != eor_pkg::PH_SECOND) begin
      r.fin = 1'b1;
      return r;
    end
    if (!($signed(d_step) < $signed(d_row) && step_pos < tw && row_pos >= 0)) begin
      if (phase == eor_pkg::PH_FIRST) load_arc(eor_pkg::PH_SECOND, sqa, sqb, semi_a);
      else phase = eor_pkg::PH_DONE;
      r.fin = (phase == eor_pkg::PH_DONE);
      return r;
    end
    if ($signed(err_acc) <= 0) begin
      err_acc = err_acc + d_step + 4 * sq_step;
    end else begin
      err_acc = err_acc + d_step - d_row + 4 * sq_step;
      d_row = d_row - 8 * sq_row;
      row_pos--;
    end
    cx = $signed(center_x);
    cy = $signed(center_y);
    if (phase == eor_pkg::PH_FIRST) begin
      px[0] = cx + step_pos; py[0] = cy + row_pos;
      px[1] = cx + step_pos; py[1] = cy - row_pos;
      px[2] = cx - step_pos; py[2] = cy + row_pos;
      px[3] = cx - step_pos; py[3] = cy - row_pos;
    end else begin
      px[0] = cx + row_pos; py[0] = cy + step_pos;
      px[1] = cx - row_pos; py[1] = cy + step_pos;
      px[2] = cx + row_pos; py[2] = cy - step_pos;
      px[3] = cx - row_pos; py[3] = cy - step_pos;
    end
    for (int i = 0; i < 4; i++) begin
      t = px[i];
      r.px[i] = t[COORD_W-1:0];
      t = py[i];
      r.py[i] = t[COORD_W-1:0];
      r.mask[i] = px[i] >= 0 && px[i] < tw && py[i] >= 0 && py[i] < th;
    end
    r.pv = 1'b1;
    d_step = d_step + 8 * sq_step;
    step_pos++;
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
    if (want !== got) begin
      mismatch_count_o++;
      $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outline_t want, got;
    if (!rst_ni) begin
      center_x = '0;
      center_y = '0;
      semi_a = '0;
      semi_b = '0;
      target_w = eor_pkg::TARGET_WIDTH_RST;
      target_h = eor_pkg::TARGET_HEIGHT_RST;
      phase = eor_pkg::PH_DONE;
      step_pos = 0;
      row_pos = 0;
      err_acc = '0;
      d_step = '0;
      d_row = '0;
      sq_step = '0;
      sq_row = '0;
      pending_outlines.delete();
      mismatch_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          eor_pkg::CFG_CENTER_X:      center_x = cfg_data_i[eor_pkg::CENTER_W-1:0];
          eor_pkg::CFG_CENTER_Y:      center_y = cfg_data_i[eor_pkg::CENTER_W-1:0];
          eor_pkg::CFG_SEMI_A:        semi_a = cfg_data_i[AXIS_W-1:0];
          eor_pkg::CFG_SEMI_B:        semi_b = cfg_data_i[AXIS_W-1:0];
          eor_pkg::CFG_TARGET_WIDTH:  target_w = cfg_data_i[eor_pkg::TARGET_W-1:0];
          eor_pkg::CFG_TARGET_HEIGHT: target_h = cfg_data_i[eor_pkg::TARGET_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) pending_outlines.push_back(trace_outline_tick(restart_i));
      if (out_valid_i && out_ready_i) begin
        if (pending_outlines.size() == 0) begin
          mismatch_count_o++;
          $display("%0t unexpected beat: expected none, got pv=%b fin=%b", $time,
                   points_valid_i, finished_i);
        end else begin
          want = pending_outlines.pop_front();
          got.px = {pt3_x_i, pt2_x_i, pt1_x_i, pt0_x_i};
          got.py = {pt3_y_i, pt2_y_i, pt1_y_i, pt0_y_i};
          got.mask = inside_mask_i;
          got.pv = points_valid_i;
          got.fin = finished_i;
          for (int i = 0; i < 4; i++) begin
            compare_field($sformatf("pt%0d_x", i), want.px[i], got.px[i]);
            compare_field($sformatf("pt%0d_y", i), want.py[i], got.py[i]);
          end
          compare_field("inside_mask", want.mask, got.mask);
          compare_field("points_valid", want.pv, got.pv);
          compare_field("finished", want.fin, got.fin);
        end
      end
      pending_o <= pending_outlines.size();
    end
  end

endmodule

// ----- bench/ellipse_outline_rasterizer_top_tb.sv -----
// testbench top for the ellipse outline rasterizer: stimulus, handshakes and verdict
`timescale 1ns / 100ps

module ellipse_outline_rasterizer_top_tb;

  localparam int COORD_W = 13;
  localparam int ITEMS   = 1250;
  localparam int LIMIT   = 400000;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_valid, cfg_ready;
  logic [eor_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [eor_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid, in_ready, restart;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [COORD_W-1:0]    pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y;
  logic [3:0]            inside_mask;
  logic                  points_valid, finished;

  int                    mismatches, pending, items;
  int                    cycles = 0;
  int                    hold_left = 0;
  int                    burst;
  bit                    idle_on;

  always #5 clk = ~clk;

  ellipse_outline_rasterizer_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .restart_i      (restart),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pt0_x_o        (pt0_x),
    .pt0_y_o        (pt0_y),
    .pt1_x_o        (pt1_x),
    .pt1_y_o        (pt1_y),
    .pt2_x_o        (pt2_x),
    .pt2_y_o        (pt2_y),
    .pt3_x_o        (pt3_x),
    .pt3_y_o        (pt3_y),
    .inside_mask_o  (inside_mask),
    .points_valid_o (points_valid),
    .finished_o     (finished)
  );

  ellipse_outline_rasterizer_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .restart_i        (restart),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .pt0_x_i          (pt0_x),
    .pt0_y_i          (pt0_y),
    .pt1_x_i          (pt1_x),
    .pt1_y_i          (pt1_y),
    .pt2_x_i          (pt2_x),
    .pt2_y_i          (pt2_y),
    .pt3_x_i          (pt3_x),
    .pt3_y_i          (pt3_y),
    .inside_mask_i    (inside_mask),
    .points_valid_i   (points_valid),
    .finished_i       (finished),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stalls in short bursts
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic put_reg(input logic [eor_pkg::CFG_IDX_W-1:0] idx,
                         input logic [eor_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_item(input logic r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart <= r;
    do @(posedge clk); while (!in_ready);
    items++;
  endtask

  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [eor_pkg::CFG_DATA_W-1:0] pick_cfg(
      input logic [eor_pkg::CFG_IDX_W-1:0] idx);
    int roll;
    logic [eor_pkg::CFG_DATA_W-1:0] d;
    roll = $urandom_range(0, 9);
    d = eor_pkg::CFG_DATA_W'($urandom_range(0, 16'hFFFF));
    case (idx)
      eor_pkg::CFG_CENTER_X, eor_pkg::CFG_CENTER_Y: begin
        if (roll == 0) d = 16'h0800;
        else if (roll == 1) d = 16'h07FF;
        else if (roll > 2) d = eor_pkg::CFG_DATA_W'($urandom_range(0, 760) - 60);
      end
      eor_pkg::CFG_SEMI_A, eor_pkg::CFG_SEMI_B: begin
        if (roll == 0) d = 16'd1023;
        else if (roll == 1) d = 16'd0;
        else if (roll > 2) d = eor_pkg::CFG_DATA_W'($urandom_range(0, 24));
      end
      eor_pkg::CFG_TARGET_WIDTH, eor_pkg::CFG_TARGET_HEIGHT: begin
        if (roll == 0) d = 16'd0;
        else if (roll == 1) d = 16'h0FFF;
        else if (roll == 2) d = 16'd2048;
        else if (roll == 3) d = 16'd1;
        else if (roll > 4) d = eor_pkg::CFG_DATA_W'($urandom_range(16, 700));
      end
      default: ;
    endcase
    return d;
  endfunction

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= eor_pkg::CFG_CENTER_X;
    cfg_data <= '0;
    in_valid <= 1'b0;
    restart <= 1'b0;
    items = 0;
    idle_on = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // advance while finished, then zero axes
    send_item(1'b0);
    send_item(1'b1);
    repeat (3) send_item(1'b0);
    in_valid <= 1'b0;
    settle();

    // small ellipse straddling the left and top borders
    put_reg(eor_pkg::CFG_CENTER_X, 16'd2);
    put_reg(eor_pkg::CFG_CENTER_Y, 16'd1);
    put_reg(eor_pkg::CFG_SEMI_A, 16'd4);
    put_reg(eor_pkg::CFG_SEMI_B, 16'd3);
    cfg_valid <= 1'b0;
    send_item(1'b1);
    repeat (13) send_item(1'b0);
    in_valid <= 1'b0;
    settle();

    // register extremes, unused data bits set
    put_reg(eor_pkg::CFG_CENTER_X, 16'h07FF);
    put_reg(eor_pkg::CFG_CENTER_Y, 16'hF800);
    put_reg(eor_pkg::CFG_SEMI_A, 16'hFFFF);
    put_reg(eor_pkg::CFG_SEMI_B, 16'h03FF);
    put_reg(eor_pkg::CFG_TARGET_WIDTH, 16'h0FFF);
    put_reg(eor_pkg::CFG_TARGET_HEIGHT, 16'h0000);
    cfg_valid <= 1'b0;
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    in_valid <= 1'b0;
    settle();

    // zero width ends each pass at once
    put_reg(eor_pkg::CFG_TARGET_WIDTH, 16'h0000);
    cfg_valid <= 1'b0;
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    in_valid <= 1'b0;

    while (items < ITEMS) begin
      idle_on = (items < ITEMS - 150) && ($urandom_range(0, 3) != 0);
      settle();
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 2) == 0) begin
          put_reg(eor_pkg::CFG_IDX_W'(k), pick_cfg(eor_pkg::CFG_IDX_W'(k)));
        end
      end
      cfg_valid <= 1'b0;
      if ($urandom_range(0, 4) != 0) send_item(1'b1);
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 60);
      repeat (burst) send_item($urandom_range(0, 19) == 0);
      in_valid <= 1'b0;
    end

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
